>>> hdl/lsd_pkg.sv
// shared constants, codes and controller/datapath handshake structs
// for the list search and duplicate removal engine
// no dependencies
package lsd_pkg;

    localparam int DEPTH       = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int TALLY_W  = 6;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR     = 3'd0,
        FUNC_APPEND    = 3'd1,
        FUNC_SEARCH    = 3'd2,
        FUNC_COUNT     = 3'd3,
        FUNC_REMOVE    = 3'd4,
        FUNC_OVERWRITE = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_NO_DUP    = 3'd2,
        STAT_PAST_END  = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } lsd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic stall;
        logic out_free;
    } lsd_stat_t;

endpackage

>>> hdl/list_search_dedup_engine.sv
// list search, duplicate count and duplicate removal engine, top level
// clear, append and overwrite register their result once the output is free;
// search, count and remove walk the list one element per cycle, except while a search
// match waits on a held result; one request in flight, the next taken the cycle after
// its result is registered, so requests also wait while a result is held off
// reset: synchronous active low, empties the list; element ram is not cleared
// depends on lsd_pkg, lsd_ctrl, lsd_dpath, lsd_ram
module list_search_dedup_engine
    import lsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // value[31:0], position[36:32], zero pad
    input  logic [2:0]  s_tuser,  // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // status[2:0], match_position[7:3], tally[13:8], zero pad
    output logic        m_tlast
);

    lsd_cmd_t            cmd;
    lsd_stat_t           stat;
    logic [STATUS_W-1:0] res_status;
    logic [POS_W-1:0]    res_mpos;
    logic [TALLY_W-1:0]  res_tally;

    lsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[FUNC_W-1:0]),
        .cmd      (cmd),
        .stat     (stat)
    );

    lsd_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_func     (s_tuser[FUNC_W-1:0]),
        .in_value    (s_tdata[VALUE_W-1:0]),
        .in_position (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (res_status),
        .out_mpos    (res_mpos),
        .out_tally   (res_tally),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, res_tally, res_mpos, res_status};

endmodule

>>> hdl/lsd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/lsd_ctrl.sv
// controller state machine: request intake, element walk sequencing, final result
// depends on lsd_pkg
module lsd_ctrl
    import lsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FUNC_W-1:0] func,
    output lsd_cmd_t          cmd,
    input  lsd_stat_t         stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    func_t  func_in;

    assign func_in = func_t'(func);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (func_in inside {FUNC_SEARCH, FUNC_COUNT, FUNC_REMOVE}) begin
                        state_next = ST_SCAN;
                    end else if (func_in inside {FUNC_CLEAR, FUNC_APPEND, FUNC_OVERWRITE}) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.step = !stat.stall;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/lsd_dpath.sv
// datapath: list length, element ram, walk counters, match logic, result register
// depends on lsd_pkg and lsd_ram
module lsd_dpath
    import lsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic [POS_W-1:0]    in_position,
    input  lsd_cmd_t            cmd,
    output lsd_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [POS_W-1:0]    out_mpos,
    output logic [TALLY_W-1:0]  out_tally,
    output logic                out_last
);

    func_t                op_reg, op_next;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                 data_vld_reg, data_vld_next;
    logic [LEN_W-1:0]     hits_reg, hits_next;
    logic [LEN_W-1:0]     wr_idx_reg, wr_idx_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]    pend_pos_reg, pend_pos_next;
    logic [RES_W-1:0]     res_cnt_reg, res_cnt_next;
    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg, out_status_next;
    logic [POS_W-1:0]     out_mpos_reg, out_mpos_next;
    logic [TALLY_W-1:0]   out_tally_reg, out_tally_next;
    logic                 out_last_reg, out_last_next;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [VALUE_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [VALUE_W-1:0]   ram_rd_data;

    logic                 out_free;
    logic                 cap;
    logic                 proc;
    logic                 more;
    logic                 is_match;
    logic                 list_full;
    logic                 past_end;
    logic                 compact_wr;

    lsd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_vld_reg || out_ready;
    assign cap       = (op_reg == FUNC_SEARCH) && (res_cnt_reg == RES_W'(MAX_RESULTS));
    assign proc      = data_vld_reg && !cap;
    assign more      = !cap && (rd_idx_reg < len_reg);
    assign is_match  = (ram_rd_data == key_reg);
    assign list_full = (len_reg >= LEN_W'(DEPTH));
    assign past_end  = (CMP_W'(pos_reg) >= CMP_W'(len_reg));

    assign stat.scan_done = !proc && !more;
    assign stat.stall     = proc && (op_reg == FUNC_SEARCH) && is_match && pend_vld_reg
                            && !out_free;
    assign stat.out_free  = out_free;

    assign compact_wr = cmd.step && proc && (op_reg == FUNC_REMOVE)
                        && (!is_match || (hits_reg == '0));

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        data_vld_next   = data_vld_reg;
        hits_next       = hits_reg;
        wr_idx_next     = wr_idx_reg;
        pend_vld_next   = pend_vld_reg;
        pend_pos_next   = pend_pos_reg;
        res_cnt_next    = res_cnt_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        out_status_next = out_status_reg;
        out_mpos_next   = out_mpos_reg;
        out_tally_next  = out_tally_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wr_idx_reg[ADDR_W-1:0];
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;

        if (cmd.load) begin
            op_next       = func_t'(in_func);
            key_next      = in_value;
            pos_next      = in_position;
            rd_idx_next   = '0;
            data_vld_next = 1'b0;
            hits_next     = '0;
            wr_idx_next   = '0;
            pend_vld_next = 1'b0;
            res_cnt_next  = '0;
        end

        if (cmd.step) begin
            if (proc) begin
                case (op_reg)
                    FUNC_SEARCH: begin
                        if (is_match) begin
                            if (pend_vld_reg) begin
                                out_vld_next    = 1'b1;
                                out_status_next = STAT_OK;
                                out_mpos_next   = POS_W'(pend_pos_reg);
                                out_tally_next  = '0;
                                out_last_next   = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_pos_next = cmp_idx_reg;
                            res_cnt_next  = res_cnt_reg + RES_W'(1);
                        end
                    end
                    FUNC_COUNT: begin
                        if (is_match) begin
                            hits_next = hits_reg + LEN_W'(1);
                        end
                    end
                    FUNC_REMOVE: begin
                        if (is_match) begin
                            hits_next = hits_reg + LEN_W'(1);
                        end
                        if (compact_wr) begin
                            ram_wr_en   = 1'b1;
                            wr_idx_next = wr_idx_reg + LEN_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (more) begin
                ram_rd_en     = 1'b1;
                cmp_idx_next  = rd_idx_reg[ADDR_W-1:0];
                rd_idx_next   = rd_idx_reg + LEN_W'(1);
                data_vld_next = 1'b1;
            end else begin
                data_vld_next = 1'b0;
            end
        end

        if (cmd.finish) begin
            out_vld_next    = 1'b1;
            out_status_next = STAT_OK;
            out_mpos_next   = '0;
            out_tally_next  = '0;
            out_last_next   = 1'b1;
            case (op_reg)
                FUNC_CLEAR: begin
                    len_next = '0;
                end
                FUNC_APPEND: begin
                    if (list_full) begin
                        out_status_next = STAT_FULL;
                        out_tally_next  = TALLY_W'(len_reg);
                    end else begin
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = len_reg[ADDR_W-1:0];
                        ram_wr_data    = key_reg;
                        len_next       = len_reg + LEN_W'(1);
                        out_tally_next = TALLY_W'(len_reg + LEN_W'(1));
                    end
                end
                FUNC_SEARCH: begin
                    if (pend_vld_reg) begin
                        out_mpos_next = POS_W'(pend_pos_reg);
                    end else begin
                        out_status_next = STAT_NOT_FOUND;
                    end
                end
                FUNC_COUNT: begin
                    if (hits_reg <= LEN_W'(1)) begin
                        out_status_next = STAT_NO_DUP;
                    end else begin
                        out_tally_next = TALLY_W'(hits_reg - LEN_W'(1));
                    end
                end
                FUNC_REMOVE: begin
                    len_next       = wr_idx_reg;
                    out_tally_next = TALLY_W'(wr_idx_reg);
                end
                FUNC_OVERWRITE: begin
                    if (past_end) begin
                        out_status_next = STAT_PAST_END;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(pos_reg);
                        ram_wr_data = key_reg;
                    end
                end
                default: begin
                    out_vld_next = out_vld_reg && !out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            data_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            op_reg       <= FUNC_CLEAR;
            rd_idx_reg   <= '0;
            hits_reg     <= '0;
            wr_idx_reg   <= '0;
            res_cnt_reg  <= '0;
        end else begin
            len_reg      <= len_next;
            data_vld_reg <= data_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            op_reg       <= op_next;
            rd_idx_reg   <= rd_idx_next;
            hits_reg     <= hits_next;
            wr_idx_reg   <= wr_idx_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        cmp_idx_reg    <= cmp_idx_next;
        pend_pos_reg   <= pend_pos_next;
        out_status_reg <= out_status_next;
        out_mpos_reg   <= out_mpos_next;
        out_tally_reg  <= out_tally_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_mpos   = out_mpos_reg;
    assign out_tally  = out_tally_reg;
    assign out_last   = out_last_reg;

    // list never grows past the ram
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(DEPTH))
        else $error("list length exceeds depth");

    // a held result is never overwritten by a new one
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_ready) |=>
            (out_vld_reg && $stable(out_status_reg) && $stable(out_mpos_reg)
             && $stable(out_tally_reg) && $stable(out_last_reg)))
        else $error("pending result overwritten");

    // compaction writes never overtake the element being examined
    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        compact_wr |-> (wr_idx_reg <= LEN_W'(cmp_idx_reg)))
        else $error("compaction write ahead of read");

endmodule
